/* src/name_registry_lookup_unit_defines.svh */
// ----------------------------------------------------------------------------
// name registry lookup unit assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef NAME_REGISTRY_LOOKUP_UNIT_DEFINES_SVH
`define NAME_REGISTRY_LOOKUP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NRL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define NRL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NRL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define NRL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* src/nrl_pkg.sv */
// ----------------------------------------------------------------------------
// nrl_pkg
// shared sizes, codes and command type of the name registry lookup unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrl_pkg;

   localparam int NUM_ENTRIES = 256;
   localparam int NAME_BYTES  = 50;

   localparam int HOST_W      = 8;
   localparam int BYTE_W      = 8;
   localparam int WORD_BYTES  = 8;
   localparam int WORD_W      = WORD_BYTES * BYTE_W;
   localparam int BSEL_W      = $clog2(WORD_BYTES);
   localparam int NAME_WORDS  = (NAME_BYTES + WORD_BYTES - 1) / WORD_BYTES;
   localparam int WORD_IDX_W  = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
   localparam int POS_W       = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam int ENTRY_W     = $clog2(NUM_ENTRIES);

   // two key slots, one per queue position
   localparam int KEY_DEPTH   = 2 << WORD_IDX_W;
   localparam int NAME_DEPTH  = NUM_ENTRIES << WORD_IDX_W;
   localparam int KEY_ADDR_W  = 1 + WORD_IDX_W;
   localparam int NAME_ADDR_W = ENTRY_W + WORD_IDX_W;

   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   localparam logic ACT_REGISTER = 1'b0;
   localparam logic ACT_FIND     = 1'b1;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_FIND    = 1'b1;

   typedef struct packed {
      logic              action;
      logic [HOST_W-1:0] host;
      logic              slot;
   } cmd_type;

endpackage

/* src/name_registry_lookup_unit.sv */
// ----------------------------------------------------------------------------
// name_registry_lookup_unit
// bytes are accepted one per cycle while the two-entry command queue has room
// register: copies the key into the table word by word (key read, then table write)
// find: scans the entries in order, skipping invalid ones and comparing valid ones
// word by word with the key; the lowest matching entry is reported, else not found
// reset: synchronous; clears all valid marks, queue and byte position at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module name_registry_lookup_unit
   import nrl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // host_id [7:0], name_byte [15:8]
   input  logic                  req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // found [0], host_index [8:1], zero
   output logic                  rsp_tuser    // reply_kind
);

   logic                  q_full;
   logic                  q_push;
   cmd_type               q_push_cmd;
   logic                  q_pop;
   logic                  q_valid;
   cmd_type               q_head;
   logic                  key_wr_en;
   logic [KEY_ADDR_W-1:0] key_wr_addr;
   logic [WORD_W-1:0]     key_wr_data;
   logic                  key_rd_en;
   logic [KEY_ADDR_W-1:0] key_rd_addr;
   logic [WORD_W-1:0]     key_rd_data;

   nrl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_push_cmd),
      .key_wr_en   (key_wr_en),
      .key_wr_addr (key_wr_addr),
      .key_wr_data (key_wr_data)
   );

   nrl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   nrl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   nrl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_head),
      .q_pop       (q_pop),
      .key_rd_en   (key_rd_en),
      .key_rd_addr (key_rd_addr),
      .key_rd_data (key_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* src/nrl_ram.sv */
// ----------------------------------------------------------------------------
// nrl_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/nrl_front.sv */
// ----------------------------------------------------------------------------
// nrl_front
// takes name bytes, packs them into key words and queues a command per name
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrl_front
   import nrl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd,
   output logic                  key_wr_en,
   output logic [KEY_ADDR_W-1:0] key_wr_addr,
   output logic [WORD_W-1:0]     key_wr_data
);

   logic [POS_W-1:0]      pos_ff,  pos_in;
   logic [BSEL_W-1:0]     bsel_ff, bsel_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic                  slot_ff, slot_in;
   logic                  act_ff,  act_in;
   logic [HOST_W-1:0]     host_ff, host_in;
   logic [WORD_W-1:0]     asm_ff,  asm_in;
   logic                  accept;
   logic                  first_byte;
   logic                  last_byte;
   logic                  word_end;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign first_byte = (pos_ff == '0);
   assign last_byte  = (pos_ff == POS_W'(NAME_BYTES - 1));
   assign word_end   = (bsel_ff == BSEL_W'(WORD_BYTES - 1)) || last_byte;

   always_comb begin
      pos_in  = pos_ff;
      bsel_in = bsel_ff;
      word_in = word_ff;
      slot_in = slot_ff;
      act_in  = act_ff;
      host_in = host_ff;
      asm_in  = asm_ff;
      if (accept) begin
         if (first_byte) begin
            act_in  = req_tuser;
            host_in = req_tdata[HOST_W-1:0];
         end
         // unused tail bytes of a word stay zero in key and table alike
         if (bsel_ff == '0) begin
            asm_in = '0;
         end
         asm_in[bsel_ff*BYTE_W +: BYTE_W] = req_tdata[HOST_W +: BYTE_W];
         if (last_byte) begin
            pos_in  = '0;
            bsel_in = '0;
            word_in = '0;
            slot_in = !slot_ff;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (bsel_ff == BSEL_W'(WORD_BYTES - 1)) begin
               bsel_in = '0;
               word_in = word_ff + 1'b1;
            end else begin
               bsel_in = bsel_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         bsel_ff <= '0;
         word_ff <= '0;
         slot_ff <= 1'b0;
         act_ff  <= ACT_REGISTER;
         host_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         bsel_ff <= bsel_in;
         word_ff <= word_in;
         slot_ff <= slot_in;
         act_ff  <= act_in;
         host_ff <= host_in;
      end
      asm_ff <= asm_in;
   end

   assign key_wr_en   = accept && word_end;
   assign key_wr_addr = {slot_ff, word_ff};
   assign key_wr_data = asm_in;

   assign q_push      = accept && last_byte;
   assign q_cmd       = '{action: act_in, host: host_in, slot: slot_ff};

endmodule

/* src/nrl_queue.sv */
// ----------------------------------------------------------------------------
// nrl_queue
// two-entry command queue between the byte front end and the search engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrl_queue
   import nrl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

endmodule

/* src/nrl_back.sv */
// ----------------------------------------------------------------------------
// nrl_back
// carries out queued commands: copies a key into the table or scans for it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "name_registry_lookup_unit_defines.svh"

module nrl_back
   import nrl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  cmd_type                q_cmd,
   output logic                   q_pop,
   output logic                   key_rd_en,
   output logic [KEY_ADDR_W-1:0]  key_rd_addr,
   input  logic [WORD_W-1:0]      key_rd_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CMP_RD,
      S_CMP,
      S_COPY_RD,
      S_COPY_WR
   } state_type;

   state_type             state_ff, state_in;
   logic [ENTRY_W-1:0]    entry_ff, entry_in;
   logic [WORD_IDX_W-1:0] w_ff,     w_in;
   logic [NUM_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  kind_ff,  kind_in;
   logic                  found_ff, found_in;
   logic [ENTRY_W-1:0]    index_ff, index_in;

   logic                  name_rd_en;
   logic                  name_wr_en;
   logic [WORD_W-1:0]     name_rd_data;
   logic [ENTRY_W-1:0]    host_entry;
   logic                  host_ok;
   logic                  last_entry;
   logic                  last_word;

   assign host_entry = q_cmd.host[ENTRY_W-1:0];
   assign host_ok    = ({1'b0, q_cmd.host} < (HOST_W + 1)'(NUM_ENTRIES));
   assign last_entry = (entry_ff == ENTRY_W'(NUM_ENTRIES - 1));
   assign last_word  = (w_ff == WORD_IDX_W'(NAME_WORDS - 1));

   assign key_rd_addr = {q_cmd.slot, w_ff};

   nrl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NAME_DEPTH)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (name_wr_en),
      .wr_addr ({host_entry, w_ff}),
      .wr_data (key_rd_data),
      .rd_en   (name_rd_en),
      .rd_addr ({entry_ff, w_ff}),
      .rd_data (name_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      entry_in       = entry_ff;
      w_in           = w_ff;
      entry_valid_in = entry_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      kind_in        = kind_ff;
      found_in       = found_ff;
      index_in       = index_ff;
      q_pop          = 1'b0;
      key_rd_en      = 1'b0;
      name_rd_en     = 1'b0;
      name_wr_en     = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            // start only with the result register free
            if (q_valid && !rsp_valid_ff) begin
               w_in     = '0;
               entry_in = '0;
               if (q_cmd.action == ACT_FIND) begin
                  state_in = S_SCAN;
               end else if (host_ok) begin
                  state_in = S_COPY_RD;
               end else begin
                  // host beyond the table: acknowledge, store nothing
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_ACK;
                  found_in     = 1'b0;
                  index_in     = '0;
                  q_pop        = 1'b1;
               end
            end
         end
         S_SCAN: begin
            w_in = '0;
            if (entry_valid_ff[entry_ff]) begin
               state_in = S_CMP_RD;
            end else if (last_entry) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_FIND;
               found_in     = 1'b0;
               index_in     = '0;
               q_pop        = 1'b1;
               state_in     = S_IDLE;
            end else begin
               entry_in = entry_ff + 1'b1;
            end
         end
         S_CMP_RD: begin
            key_rd_en  = 1'b1;
            name_rd_en = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (key_rd_data == name_rd_data) begin
               if (last_word) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_FIND;
                  found_in     = 1'b1;
                  index_in     = entry_ff;
                  q_pop        = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = S_CMP_RD;
               end
            end else if (last_entry) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_FIND;
               found_in     = 1'b0;
               index_in     = '0;
               q_pop        = 1'b1;
               state_in     = S_IDLE;
            end else begin
               entry_in = entry_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_COPY_RD: begin
            key_rd_en = 1'b1;
            state_in  = S_COPY_WR;
         end
         S_COPY_WR: begin
            name_wr_en = 1'b1;
            if (last_word) begin
               entry_valid_in[host_entry] = 1'b1;
               rsp_valid_in               = 1'b1;
               kind_in                    = KIND_ACK;
               found_in                   = 1'b0;
               index_in                   = '0;
               q_pop                      = 1'b1;
               state_in                   = S_IDLE;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = S_COPY_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_ff       <= '0;
         w_ff           <= '0;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         kind_ff        <= KIND_ACK;
         found_ff       <= 1'b0;
         index_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         entry_ff       <= entry_in;
         w_ff           <= w_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         kind_ff        <= kind_in;
         found_ff       <= found_in;
         index_ff       <= index_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = RSP_DATA_W'({index_ff, found_ff});

   `NRL_ASSERT_IMP(a_busy_has_cmd, clock, reset, state_ff != S_IDLE, q_valid,
      "engine busy with an empty command queue")
   `NRL_ASSERT_IMP(a_ack_is_clean, clock, reset, rsp_valid_ff && (kind_ff == KIND_ACK),
      !found_ff && (index_ff == '0), "acknowledge carries a hit or an index")
   `NRL_ASSERT_IMP(a_hit_is_valid, clock, reset, rsp_valid_ff && found_ff,
      entry_valid_ff[index_ff], "hit reported on an entry that was never registered")
   `NRL_ASSERT_NXT(a_pop_to_idle, clock, reset, q_pop, (state_ff == S_IDLE) && rsp_valid_ff,
      "command retired without a reply")

endmodule

/* verif/tb_name_registry_lookup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_name_registry_lookup_unit
// streams 50-byte register and find names into the lookup unit, with random
// gaps on both sides, and checks every reply against a behavioural copy of the
// host table kept inside the bench.
// ----------------------------------------------------------------------------

module tb_name_registry_lookup_unit;
   import nrl_pkg::*;

   localparam int  CLK_HALF     = 5;
   localparam int  CYCLE_LIMIT  = 1_000_000;
   localparam int  DRAIN_CYCLES = 4000;
   localparam int  RANDOM_NAMES = 21;

   typedef logic [NAME_BYTES*BYTE_W-1:0] name_bits_type;

   typedef struct packed {
      logic              action;
      logic [HOST_W-1:0] host;
      logic [BYTE_W-1:0] name_byte;
   } name_byte_item_type;

   typedef struct packed {
      logic              kind;
      logic              found;
      logic [HOST_W-1:0] host_index;
   } lookup_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   name_registry_lookup_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   name_byte_item_type bytes_to_send [$];
   lookup_reply_type   replies_due [$];
   name_bits_type      known_names [$];
   int                 mismatches   = 0;
   int                 replies_seen = 0;
   int                 cycle_count  = 0;

   // predictor state: host table and the name being assembled
   logic              entry_valid [NUM_ENTRIES];
   name_bits_type     entry_name  [NUM_ENTRIES];
   name_bits_type     key_name;
   int                key_pos = 0;
   logic              held_action = ACT_REGISTER;
   logic [HOST_W-1:0] held_host = '0;

   lookup_reply_type   want;
   name_byte_item_type next_item;

   // long stretch with no gaps on either side
   wire quiet = (replies_seen >= 15) && (replies_seen < 30);

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      foreach (entry_valid[i]) entry_valid[i] = 1'b0;
   end

   task automatic absorb_byte(input logic act, input logic [HOST_W-1:0] host,
                              input logic [BYTE_W-1:0] nb);
      lookup_reply_type reply;
      if (key_pos == 0) begin
         held_action = act;
         held_host   = host;
      end
      key_name[key_pos*BYTE_W +: BYTE_W] = nb;
      if (key_pos < NAME_BYTES - 1) begin
         key_pos++;
      end else begin
         key_pos = 0;
         reply   = '0;
         if (held_action == ACT_REGISTER) begin
            reply.kind = KIND_ACK;
            if (held_host < NUM_ENTRIES) begin
               entry_name[held_host]  = key_name;
               entry_valid[held_host] = 1'b1;
            end
         end else begin
            reply.kind = KIND_FIND;
            for (int e = 0; e < NUM_ENTRIES; e++) begin
               if (!reply.found && entry_valid[e] && entry_name[e] == key_name) begin
                  reply.found      = 1'b1;
                  reply.host_index = e[HOST_W-1:0];
               end
            end
         end
         replies_due.push_back(reply);
      end
   endtask

   function automatic name_bits_type random_name();
      name_bits_type n;
      for (int i = 0; i < NAME_BYTES; i++) n[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(255));
      return n;
   endfunction

   function automatic name_bits_type flip_byte(input name_bits_type n, input int pos);
      n[pos*BYTE_W +: BYTE_W] ^= BYTE_W'($urandom_range(255, 1));
      return n;
   endfunction

   // action and host only count on byte zero; the rest carry noise
   task automatic queue_name(input logic act, input logic [HOST_W-1:0] host,
                             input name_bits_type n);
      name_byte_item_type item;
      for (int i = 0; i < NAME_BYTES; i++) begin
         item.action    = (i == 0) ? act : logic'($urandom_range(1));
         item.host      = (i == 0) ? host : HOST_W'($urandom_range(255));
         item.name_byte = n[i*BYTE_W +: BYTE_W];
         bytes_to_send.push_back(item);
      end
      if (act == ACT_REGISTER) known_names.push_back(n);
   endtask

   task automatic build_stimulus();
      name_bits_type name_a;
      name_bits_type name_b;
      name_bits_type pick;
      int            roll;
      logic [HOST_W-1:0] host;
      name_a = random_name();
      name_b = random_name();
      // empty table, extremes of host and name bytes
      queue_name(ACT_FIND, 8'd0, random_name());
      queue_name(ACT_REGISTER, 8'd0, '0);
      queue_name(ACT_REGISTER, 8'd255, '1);
      queue_name(ACT_FIND, 8'd255, '0);
      queue_name(ACT_FIND, 8'd0, '1);
      // same name twice, lowest index wins
      queue_name(ACT_REGISTER, 8'd7, name_a);
      queue_name(ACT_REGISTER, 8'd3, name_a);
      queue_name(ACT_FIND, 8'd128, name_a);
      // overwrite the lower entry
      queue_name(ACT_REGISTER, 8'd3, name_b);
      queue_name(ACT_FIND, 8'd1, name_a);
      queue_name(ACT_FIND, 8'd1, name_b);
      // near misses in the last and the first byte
      queue_name(ACT_FIND, 8'd0, flip_byte(name_a, NAME_BYTES - 1));
      queue_name(ACT_FIND, 8'd0, flip_byte(name_a, 0));

      for (int k = 0; k < RANDOM_NAMES; k++) begin
         roll = $urandom_range(99);
         pick = known_names[$urandom_range(known_names.size() - 1)];
         host = ($urandom_range(1) == 1) ? HOST_W'($urandom_range(7))
                                         : HOST_W'($urandom_range(255));
         if (roll < 25) begin
            queue_name(ACT_REGISTER, host, random_name());
         end else if (roll < 35) begin
            queue_name(ACT_REGISTER, host, pick);
         end else if (roll < 45) begin
            queue_name(ACT_REGISTER, host,
                       flip_byte(pick, $urandom_range(NAME_BYTES - 1)));
         end else if (roll < 75) begin
            queue_name(ACT_FIND, HOST_W'($urandom_range(255)), pick);
         end else if (roll < 90) begin
            queue_name(ACT_FIND, HOST_W'($urandom_range(255)),
                       flip_byte(pick, $urandom_range(NAME_BYTES - 1)));
         end else begin
            queue_name(ACT_FIND, HOST_W'($urandom_range(255)), random_name());
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (bytes_to_send.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
            next_item   = bytes_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {next_item.name_byte, next_item.host};
            req_tuser  <= next_item.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // reply side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= quiet || ($urandom_range(99) >= 9);
   end

   // every accepted byte goes through the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         absorb_byte(req_tuser, req_tdata[HOST_W-1:0], req_tdata[HOST_W +: BYTE_W]);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen <= replies_seen + 1;
         if (replies_due.size() == 0) begin
            mismatches++;
            $display("%0t: reply with none pending: kind %0b tdata %h", $time,
                     rsp_tuser, rsp_tdata);
         end else begin
            want = replies_due.pop_front();
            if (rsp_tuser !== want.kind) begin
               mismatches++;
               $display("%0t: reply_kind expected %0b actual %0b", $time,
                        want.kind, rsp_tuser);
            end
            if (rsp_tdata[0] !== want.found) begin
               mismatches++;
               $display("%0t: found expected %0b actual %0b", $time,
                        want.found, rsp_tdata[0]);
            end
            if (rsp_tdata[HOST_W:1] !== want.host_index) begin
               mismatches++;
               $display("%0t: host_index expected %0d actual %0d", $time,
                        want.host_index, rsp_tdata[HOST_W:1]);
            end
            if (rsp_tdata[RSP_DATA_W-1:HOST_W+1] !== '0) begin
               mismatches++;
               $display("%0t: padding expected 0 actual %h", $time,
                        rsp_tdata[RSP_DATA_W-1:HOST_W+1]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_name_registry_lookup_unit: errors");
         $finish;
      end
   end

   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (bytes_to_send.size() > 0 || req_tvalid) @(posedge clock);
      while (replies_due.size() > 0) @(posedge clock);
      // catch any reply that should never come
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && replies_due.size() == 0)
         $display("tb_name_registry_lookup_unit: clean");
      else
         $display("tb_name_registry_lookup_unit: errors");
      $finish;
   end

endmodule

/* name_registry_lookup_unit.f */
+incdir+src
src/nrl_pkg.sv
src/nrl_ram.sv
src/nrl_front.sv
src/nrl_queue.sv
src/nrl_back.sv
src/name_registry_lookup_unit.sv
verif/tb_name_registry_lookup_unit.sv
